@@ rtl/itok_pkg.sv @@
// Shared types and constants for the INI text tokenizer.
package itok_pkg;

  // Fixed token limit; counts are 8 bits wide, so the limit never exceeds 255.
  localparam int MAX_TOKEN = 255;
  localparam int TOKEN_LIMIT_INT = (MAX_TOKEN > 255) ? 255 : MAX_TOKEN;
  localparam logic [7:0] TOKEN_LIMIT = 8'(TOKEN_LIMIT_INT);

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  typedef enum logic {
    KIND_TEXT = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ROLE_NONE  = 2'd0,
    ROLE_KEY   = 2'd1,
    ROLE_VALUE = 2'd2,
    ROLE_DROP  = 2'd3
  } role_t;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_SECTION = 2'd1,
    EVT_PAIR    = 2'd2
  } rec_event_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    rec_event_t record_event;
    role_t      char_role;
    logic [7:0] value_len;
    logic [7:0] key_len;
    logic [7:0] char_pos;
  } result_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/itok_stage.sv @@
// Pipeline register with valid/ready flow control.
module itok_stage #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             valid;
  logic [WIDTH-1:0] data;

  // Load whenever the slot is empty or being drained this cycle.
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

@@ rtl/itok_step.sv @@
// Tokenizer state and per-byte classification logic.
module itok_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  itok_pkg::item_t   item,
  output itok_pkg::result_t result
);

  logic       key_mode, key_mode_next;
  logic       in_section, in_section_next;
  logic [7:0] key_count, key_count_next;
  logic [7:0] value_count, value_count_next;

  logic       close;
  logic [7:0] cur_count;
  logic       is_text;
  logic [7:0] b;

  always_comb begin
    b                = item.text_byte;
    is_text          = (item.kind == itok_pkg::KIND_TEXT);
    close            = 1'b0;
    key_mode_next    = key_mode;
    in_section_next  = in_section;
    key_count_next   = key_count;
    value_count_next = value_count;
    cur_count        = key_mode ? key_count : value_count;

    result.char_role    = itok_pkg::ROLE_NONE;
    result.char_pos     = 8'd0;
    result.record_event = itok_pkg::EVT_NONE;
    result.key_len      = 8'd0;
    result.value_len    = 8'd0;

    if (!is_text) begin
      close         = 1'b1;
      key_mode_next = 1'b1;
    end else if (b == itok_pkg::CH_LBRACKET) begin
      in_section_next = 1'b1;
    end else if (b == itok_pkg::CH_RBRACKET) begin
      close = 1'b1;
    end else if (b == itok_pkg::CH_HASH || b == itok_pkg::CH_CR || b == itok_pkg::CH_LF) begin
      close         = 1'b1;
      key_mode_next = 1'b1;
    end else if (b == itok_pkg::CH_EQUAL) begin
      key_mode_next = 1'b0;
    end else if (b > itok_pkg::CH_SPACE) begin
      if (cur_count < itok_pkg::TOKEN_LIMIT) begin
        result.char_role = key_mode ? itok_pkg::ROLE_KEY : itok_pkg::ROLE_VALUE;
        result.char_pos  = cur_count;
        if (key_mode) begin
          key_count_next = key_count + 8'd1;
        end else begin
          value_count_next = value_count + 8'd1;
        end
      end else begin
        // Token full: drop the character, hold the count.
        result.char_role = itok_pkg::ROLE_DROP;
      end
    end

    if (close) begin
      if (in_section) begin
        if (key_count != 8'd0) begin
          result.record_event = itok_pkg::EVT_SECTION;
        end
      end else if (key_count != 8'd0 && value_count != 8'd0) begin
        result.record_event = itok_pkg::EVT_PAIR;
      end
      if (result.record_event != itok_pkg::EVT_NONE) begin
        result.key_len   = key_count;
        result.value_len = value_count;
      end
      in_section_next  = 1'b0;
      key_count_next   = 8'd0;
      value_count_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode    <= 1'b1;
      in_section  <= 1'b0;
      key_count   <= 8'd0;
      value_count <= 8'd0;
    end else if (fire) begin
      key_mode    <= key_mode_next;
      in_section  <= in_section_next;
      key_count   <= key_count_next;
      value_count <= value_count_next;
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    key_count <= itok_pkg::TOKEN_LIMIT && value_count <= itok_pkg::TOKEN_LIMIT)
    else $error("token count beyond limit");

  a_section_len: assert property (@(posedge clk) disable iff (rst)
    result.record_event == itok_pkg::EVT_SECTION |-> result.key_len != 8'd0 && in_section)
    else $error("section reported without key or section mark");

  a_pair_len: assert property (@(posedge clk) disable iff (rst)
    result.record_event == itok_pkg::EVT_PAIR |->
      result.key_len != 8'd0 && result.value_len != 8'd0)
    else $error("pair reported with empty key or value");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    fire && result.record_event != itok_pkg::EVT_NONE |=>
      key_count == 8'd0 && value_count == 8'd0 && !in_section)
    else $error("counts not cleared after record close");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    result.char_role == itok_pkg::ROLE_DROP |-> cur_count == itok_pkg::TOKEN_LIMIT)
    else $error("character dropped below token limit");

endmodule

@@ rtl/ini_text_tokenizer_core.sv @@
// Top level of the INI text tokenizer: input register, tokenizer logic, result register.
//
// Streams INI text one byte per item (s_tuser = 0) and closes the stream with an
// end-of-data item (s_tuser = 1). Every item yields exactly one result item that
// tags the byte as key character, value character, ignored or dropped, with its
// position, and reports a completed section name or key/value pair with both
// lengths. One item is taken per clock cycle while the output is not back-pressured;
// the item is held in the input register, passes the combinational tokenizer logic,
// and its result is held in the result register that drives the output.
// Tokens are capped at 255 characters; further characters come back as dropped.
module ini_text_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] char_pos, [15:8] key_len, [23:16] value_len
  output logic [3:0]  m_tuser    // [1:0] char_role, [3:2] record_event
);

  itok_pkg::item_t   in_item;
  itok_pkg::item_t   st_item;
  itok_pkg::result_t step_result;
  itok_pkg::result_t out_result;

  logic [itok_pkg::ITEM_W-1:0]   st_data;
  logic [itok_pkg::RESULT_W-1:0] out_data;
  logic                          st_valid;
  logic                          res_ready;

  assign in_item.kind      = itok_pkg::kind_t'(s_tuser);
  assign in_item.text_byte = s_tdata;

  itok_stage #(.WIDTH(itok_pkg::ITEM_W)) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_item),
    .out_valid (st_valid),
    .out_ready (res_ready),
    .out_data  (st_data)
  );

  assign st_item = itok_pkg::item_t'(st_data);

  // Advance tokenizer state only when the result moves into the output register.
  itok_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (st_valid && res_ready),
    .item   (st_item),
    .result (step_result)
  );

  itok_stage #(.WIDTH(itok_pkg::RESULT_W)) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid),
    .in_ready  (res_ready),
    .in_data   (step_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign out_result = itok_pkg::result_t'(out_data);
  assign m_tdata    = {out_result.value_len, out_result.key_len, out_result.char_pos};
  assign m_tuser    = {out_result.record_event, out_result.char_role};

endmodule
